// ----- sv/tcm_pkg.sv -----
`timescale 1ns / 1ps

package tcm_pkg;

    localparam int SAMPLE_BITS_DEF  = 16;
    localparam int COLOR_BITS_DEF   = 8;
    localparam int CFG_INDEX_BITS   = 2;
    localparam int RANGE_HIGH_RESET = 32767;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_RANGE_LOW  = 2'd0,
        REG_RANGE_HIGH = 2'd1
    } tcm_reg_t;

    typedef enum logic [1:0] {
        SEG_BLUE_CYAN    = 2'd0,
        SEG_CYAN_GREEN   = 2'd1,
        SEG_GREEN_YELLOW = 2'd2,
        SEG_YELLOW_RED   = 2'd3
    } tcm_seg_t;

    typedef struct packed {
        logic valid;
        logic den_zero;
        logic neg;
        logic ovf;
    } tcm_ctl_t;

endpackage

// ----- sv/thermograph_color_map_unit.sv -----
`timescale 1ns / 1ps

// False-colour map: each signed sample is placed on a blue-cyan-green-yellow-red scale across
// range_low..range_high (a reversed range works; an empty range gives black with range_valid
// low). One sample is taken every clock unless in_stall is high; the pipeline depth is set by
// the restoring divider, which resolves one quotient bit per pipeline stage. out_stall freezes
// the whole pipeline once the output register is full, and in_stall follows it. The user must
// write the range registers only while the block is idle (the block does not enforce this);
// they then apply to the next sample.
module thermograph_color_map_unit #(
    parameter int SAMPLE_BITS = tcm_pkg::SAMPLE_BITS_DEF,
    parameter int COLOR_BITS  = tcm_pkg::COLOR_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [tcm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [SAMPLE_BITS-1:0]              cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [SAMPLE_BITS-1:0]       sample,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [COLOR_BITS-1:0]               red,
    output logic [COLOR_BITS-1:0]               green,
    output logic [COLOR_BITS-1:0]               blue,
    output logic                                range_valid
);

    localparam int SB = SAMPLE_BITS;
    localparam int CB = COLOR_BITS;
    localparam int QB = CB + 2;
    localparam int NW = SB + QB;

    localparam logic [CB-1:0] CMAX = {CB{1'b1}};
    localparam logic [QB-1:0] SPAN = {CMAX, 2'b00};
    localparam logic [QB-1:0] SEG1 = {2'b00, CMAX};
    localparam logic [QB-1:0] SEG2 = {1'b0, CMAX, 1'b0};
    localparam logic [QB-1:0] SEG3 = SEG1 + SEG2;

    // configuration
    logic signed [SB-1:0] range_low_reg;
    logic signed [SB-1:0] range_high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_low_reg  <= '0;
            range_high_reg <= SB'(tcm_pkg::RANGE_HIGH_RESET);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                tcm_pkg::REG_RANGE_LOW:  range_low_reg  <= cfg_data;
                tcm_pkg::REG_RANGE_HIGH: range_high_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // denominator, refreshed every cycle from the range registers
    logic signed [SB:0] den_full;
    logic [SB:0]        den_flip;
    logic               den_neg_reg;
    logic               den_zero_reg;
    logic [SB-1:0]      den_abs_reg;

    assign den_full = {range_high_reg[SB-1], range_high_reg}
                    - {range_low_reg[SB-1], range_low_reg};
    assign den_flip = -den_full;

    always_ff @(posedge clk)
    begin
        den_neg_reg  <= den_full[SB];
        den_zero_reg <= (den_full == '0);
        den_abs_reg  <= den_full[SB] ? den_flip[SB-1:0] : den_full[SB-1:0];
    end

    // pipeline advance
    logic out_valid_reg;
    logic adv;

    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    // stage A: input capture
    logic                 a_valid_reg;
    logic signed [SB-1:0] a_sample_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (adv)
            a_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            a_sample_reg <= sample;
    end

    // stage B: offset from low end, sign folded into numerator
    logic signed [SB:0] b_diff;
    logic signed [SB:0] b_dn;
    tcm_pkg::tcm_ctl_t  b_ctl_next;
    tcm_pkg::tcm_ctl_t  b_ctl_reg;
    logic [SB-1:0]      b_dmag_reg;

    assign b_diff = {a_sample_reg[SB-1], a_sample_reg} - {range_low_reg[SB-1], range_low_reg};
    assign b_dn   = den_neg_reg ? -b_diff : b_diff;

    always_comb
    begin
        b_ctl_next          = '0;
        b_ctl_next.valid    = a_valid_reg;
        b_ctl_next.den_zero = den_zero_reg;
        b_ctl_next.neg      = b_dn[SB];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_ctl_reg <= '0;
        else if (adv)
            b_ctl_reg <= b_ctl_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            b_dmag_reg <= b_dn[SB-1:0];
    end

    // stage C: scale by span
    tcm_pkg::tcm_ctl_t c_ctl_reg;
    logic [NW-1:0]     c_num_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_ctl_reg <= '0;
        else if (adv)
            c_ctl_reg <= b_ctl_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            c_num_reg <= NW'(b_dmag_reg) * NW'(SPAN);
    end

    // stage D and divider: overflow check, then one quotient bit per stage
    tcm_pkg::tcm_ctl_t d_ctl_next;
    tcm_pkg::tcm_ctl_t ctl_reg [0:QB];
    logic [NW-1:0]     rem_reg [0:QB];
    logic [QB-1:0]     quo_reg [0:QB];

    always_comb
    begin
        d_ctl_next     = c_ctl_reg;
        d_ctl_next.ovf = !c_ctl_reg.neg && (c_num_reg >= {den_abs_reg, {QB{1'b0}}});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg[0] <= '0;
        else if (adv)
            ctl_reg[0] <= d_ctl_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0] <= c_num_reg;
            quo_reg[0] <= '0;
        end
    end

    for (genvar j = 0; j < QB; j++)
    begin : g_div
        logic [NW-1:0] dsh;
        logic          ge;

        assign dsh = NW'(den_abs_reg) << (QB - 1 - j);
        assign ge  = rem_reg[j] >= dsh;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                ctl_reg[j+1] <= '0;
            else if (adv)
                ctl_reg[j+1] <= ctl_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[j+1] <= ge ? rem_reg[j] - dsh : rem_reg[j];
                quo_reg[j+1] <= {quo_reg[j][QB-2:0], ge};
            end
        end
    end

    // stage E: clamp, segment and fraction
    logic [QB-1:0]     e_pos;
    logic [QB-1:0]     e_rel;
    tcm_pkg::tcm_seg_t e_seg_next;
    tcm_pkg::tcm_seg_t e_seg_reg;
    logic [CB-1:0]     e_f_reg;
    tcm_pkg::tcm_ctl_t e_ctl_reg;

    always_comb
    begin
        priority if (ctl_reg[QB].neg)
            e_pos = '0;
        else if (ctl_reg[QB].ovf || quo_reg[QB] > SPAN)
            e_pos = SPAN;
        else
            e_pos = quo_reg[QB];
    end

    always_comb
    begin
        priority if (e_pos >= SEG3)
        begin
            e_seg_next = tcm_pkg::SEG_YELLOW_RED;
            e_rel      = e_pos - SEG3;
        end
        else if (e_pos >= SEG2)
        begin
            e_seg_next = tcm_pkg::SEG_GREEN_YELLOW;
            e_rel      = e_pos - SEG2;
        end
        else if (e_pos >= SEG1)
        begin
            e_seg_next = tcm_pkg::SEG_CYAN_GREEN;
            e_rel      = e_pos - SEG1;
        end
        else
        begin
            e_seg_next = tcm_pkg::SEG_BLUE_CYAN;
            e_rel      = e_pos;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e_ctl_reg <= '0;
        else if (adv)
            e_ctl_reg <= ctl_reg[QB];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_seg_reg <= e_seg_next;
            e_f_reg   <= e_rel[CB-1:0];
        end
    end

    // output register: channel mapping
    logic [CB-1:0] red_next;
    logic [CB-1:0] green_next;
    logic [CB-1:0] blue_next;
    logic [CB-1:0] red_reg;
    logic [CB-1:0] green_reg;
    logic [CB-1:0] blue_reg;
    logic          range_valid_reg;

    always_comb
    begin
        red_next   = '0;
        green_next = '0;
        blue_next  = '0;
        if (!e_ctl_reg.den_zero)
        begin
            unique case (e_seg_reg)
                tcm_pkg::SEG_BLUE_CYAN:
                begin
                    green_next = e_f_reg;
                    blue_next  = CMAX;
                end
                tcm_pkg::SEG_CYAN_GREEN:
                begin
                    green_next = CMAX;
                    blue_next  = CMAX - e_f_reg;
                end
                tcm_pkg::SEG_GREEN_YELLOW:
                begin
                    red_next   = e_f_reg;
                    green_next = CMAX;
                end
                tcm_pkg::SEG_YELLOW_RED:
                begin
                    red_next   = CMAX;
                    green_next = CMAX - e_f_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= e_ctl_reg.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            red_reg         <= red_next;
            green_reg       <= green_next;
            blue_reg        <= blue_next;
            range_valid_reg <= !e_ctl_reg.den_zero;
        end
    end

    assign out_valid   = out_valid_reg;
    assign red         = red_reg;
    assign green       = green_reg;
    assign blue        = blue_reg;
    assign range_valid = range_valid_reg;

    // checks
    a_blank_on_empty_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !range_valid_reg |-> red_reg == '0 && green_reg == '0 && blue_reg == '0)
        else $error("colour not blank for an empty range");

    a_one_channel_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && range_valid_reg |-> red_reg == CMAX || green_reg == CMAX
                                             || blue_reg == CMAX)
        else $error("no channel at full scale");

    a_neg_ovf_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg[0].valid |-> !(ctl_reg[0].neg && ctl_reg[0].ovf))
        else $error("negative and overflow flags both set");

    a_frozen_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> $stable(e_f_reg) && $stable(e_ctl_reg))
        else $error("pipeline moved while stalled");

endmodule
